>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MPM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg
// Constants, types and the control store for the 2x2 modular matrix power.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int ENTRY_W       = 30;
  localparam int EXP_IN_W      = 32;
  localparam int EXP_BITS_DFLT = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int STEP_W        = 5;

  localparam logic [ENTRY_W-1:0] MOD_PRIME = 30'd1000000007;
  // floor(2^60 / P) for Barrett reduction of a 60-bit product
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MOD_PRIME));
  localparam logic [31:0] TWO_PRIME  = 32'({2'b00, MOD_PRIME} << 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_00 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_10 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_11 = 3'd3;

  // row-major: [0]=00, [1]=01, [2]=10, [3]=11
  typedef logic [3:0][ENTRY_W-1:0] mat_t;

  localparam mat_t IDENTITY  = '{30'd1, 30'd0, 30'd0, 30'd1};
  localparam mat_t CFG_RESET = '{30'd2, 30'd3, 30'd1, 30'd0};

  // which matrix a product belongs to
  localparam logic BANK_ACC = 1'b0;
  localparam logic BANK_SQ  = 1'b1;

  // micro-operations
  localparam logic [2:0] OP_JZ     = 3'd0;  // jump when exponent is exhausted
  localparam logic [2:0] OP_JBC    = 3'd1;  // jump when low exponent bit is clear
  localparam logic [2:0] OP_ISSUE  = 3'd2;  // push one product into the multiplier
  localparam logic [2:0] OP_WAIT   = 3'd3;  // hold until the multiplier drains
  localparam logic [2:0] OP_COMMIT = 3'd4;  // take new matrices, shift exponent, jump
  localparam logic [2:0] OP_DONE   = 3'd5;  // hand the result to the output register

  localparam logic [STEP_W-1:0] STEP_START       = 5'd0;
  localparam logic [STEP_W-1:0] STEP_TEST_BIT    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_ISSUE_FIRST = 5'd2;
  localparam logic [STEP_W-1:0] STEP_SQ_FIRST    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_ISSUE_LAST  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_WAIT        = 5'd18;
  localparam logic [STEP_W-1:0] STEP_COMMIT      = 5'd19;
  localparam logic [STEP_W-1:0] STEP_DONE        = 5'd20;

  typedef struct packed {
    logic [2:0]        op;
    logic              bank;
    logic [1:0]        ent;
    logic              second;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // tag that travels with each product through the multiplier
  typedef struct packed {
    logic       vld;
    logic       bank;
    logic [1:0] ent;
    logic       second;
  } tag_t;

  function automatic logic [ENTRY_W-1:0] reduce_entry(input logic [ENTRY_W-1:0] v);
    return (v >= MOD_PRIME) ? ENTRY_W'(v - MOD_PRIME) : v;
  endfunction

  // Program: per exponent bit, optionally acc*sq, always sq*sq, then commit.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t            w;
    logic [STEP_W-1:0] k;
    w = '{op: OP_DONE, bank: BANK_ACC, ent: 2'd0, second: 1'b0, target: STEP_START};
    k = addr - STEP_ISSUE_FIRST;
    case (addr)
      STEP_START: begin
        w.op     = OP_JZ;
        w.target = STEP_DONE;
      end
      STEP_TEST_BIT: begin
        w.op     = OP_JBC;
        w.target = STEP_SQ_FIRST;
      end
      STEP_WAIT: begin
        w.op = OP_WAIT;
      end
      STEP_COMMIT: begin
        w.op     = OP_COMMIT;
        w.target = STEP_START;
      end
      STEP_DONE: begin
        w.op = OP_DONE;
      end
      default: begin
        if (addr inside {[STEP_ISSUE_FIRST:STEP_ISSUE_LAST]}) begin
          // two products per entry, back to back, first then second
          w.op     = OP_ISSUE;
          w.bank   = k[3];
          w.ent    = k[2:1];
          w.second = k[0];
        end
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/mpm_in_if.sv
// ----------------------------------------------------------------------------
// mpm_in_if
// Exponent channel: valid/ready handshake with one exponent per item.
// ----------------------------------------------------------------------------
interface mpm_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpm_pkg::EXP_IN_W-1:0]  exponent;

  modport source (output valid, output exponent, input ready);
  modport sink   (input valid, input exponent, output ready);
endinterface

>>> hdl/mpm_out_if.sv
// ----------------------------------------------------------------------------
// mpm_out_if
// Result channel: valid/ready handshake with the four entries of the power.
// ----------------------------------------------------------------------------
interface mpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpm_pkg::ENTRY_W-1:0]  power_00;
  logic [mpm_pkg::ENTRY_W-1:0]  power_01;
  logic [mpm_pkg::ENTRY_W-1:0]  power_10;
  logic [mpm_pkg::ENTRY_W-1:0]  power_11;

  modport source (output valid, output power_00, output power_01,
                  output power_10, output power_11, input ready);
  modport sink   (input valid, input power_00, input power_01,
                  input power_10, input power_11, output ready);
endinterface

>>> hdl/mpm_mulmod.sv
// ----------------------------------------------------------------------------
// mpm_mulmod
// Six-stage pipelined a*b mod P with Barrett reduction; one product per cycle.
// ----------------------------------------------------------------------------
module mpm_mulmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpm_pkg::tag_t                issue_tag,
  input  logic [mpm_pkg::ENTRY_W-1:0]  op_a,
  input  logic [mpm_pkg::ENTRY_W-1:0]  op_b,
  output mpm_pkg::tag_t                res_tag,
  output logic [mpm_pkg::ENTRY_W-1:0]  res,
  output logic                         busy
);

  localparam int NSTAGE = 6;

  mpm_pkg::tag_t                tag_r [NSTAGE];
  logic [mpm_pkg::ENTRY_W-1:0]  op_a_r, op_b_r;
  logic [59:0]                  prod_r;
  logic [61:0]                  q2;
  logic [30:0]                  q3_r;
  logic [31:0]                  plo2_r, plo3_r;
  logic [60:0]                  qp_full;
  logic [31:0]                  qp_r;
  logic [31:0]                  diff_r;
  logic [mpm_pkg::ENTRY_W-1:0]  red_nxt, red_r;
  logic [NSTAGE-1:0]            vld_vec;

  // quotient estimate from the top 31 bits of the product
  assign q2      = prod_r[59:29] * mpm_pkg::BARRETT_MU;
  assign qp_full = q3_r * mpm_pkg::MOD_PRIME;

  // remainder is below 3P, so at most two subtractions
  always_comb begin
    if (diff_r >= mpm_pkg::TWO_PRIME) begin
      red_nxt = mpm_pkg::ENTRY_W'(diff_r - mpm_pkg::TWO_PRIME);
    end else if (diff_r >= {2'b00, mpm_pkg::MOD_PRIME}) begin
      red_nxt = mpm_pkg::ENTRY_W'(diff_r - {2'b00, mpm_pkg::MOD_PRIME});
    end else begin
      red_nxt = mpm_pkg::ENTRY_W'(diff_r);
    end
  end

  always_ff @(posedge clk) begin
    op_a_r <= op_a;
    op_b_r <= op_b;
    prod_r <= op_a_r * op_b_r;
    q3_r   <= q2[61:31];
    plo2_r <= prod_r[31:0];
    qp_r   <= qp_full[31:0];
    plo3_r <= plo2_r;
    diff_r <= plo3_r - qp_r;
    red_r  <= red_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTAGE; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      tag_r[0] <= issue_tag;
      for (int i = 1; i < NSTAGE; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NSTAGE; i++) begin
      vld_vec[i] = tag_r[i].vld;
    end
  end

  assign busy    = |vld_vec;
  assign res_tag = tag_r[NSTAGE-1];
  assign res     = red_r;

endmodule

>>> hdl/matrix_power_2x2_mod_prime.sv
// ----------------------------------------------------------------------------
// matrix_power_2x2_mod_prime
// Raises the configured 2x2 matrix to an exponent mod 1000000007 by
// square-and-multiply, low bit first, under a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                               | handshake
//  in_ch    | in        | exponent (32b)                        | valid/ready
//  out_ch   | out       | power_00/01/10/11 (30b each)          | valid/ready
//  cfg_*    | in        | cfg_index (3b), cfg_wdata (30b)       | cfg_we
//
//  One item at a time. Per exponent bit up to the highest set bit, acc*sq
//  products are issued when the bit is set and sq*sq products always, all
//  through the shared six-stage mod-P multiplier, drained before commit.
//  Synchronous active-low reset; no clearing pass. A stalled result waits in
//  the output register while the next exponent is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_power_2x2_mod_prime #(
  parameter int EXP_BITS = mpm_pkg::EXP_BITS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpm_pkg::ENTRY_W-1:0]    cfg_wdata,
  mpm_in_if.sink                         in_ch,
  mpm_out_if.source                      out_ch
);

  localparam int EXP_W = (EXP_BITS < mpm_pkg::EXP_IN_W) ? EXP_BITS : mpm_pkg::EXP_IN_W;

  mpm_pkg::mat_t                cfg_r;
  mpm_pkg::mat_t                acc_r, sq_r, nacc_r, nsq_r, out_mat_r;
  logic [EXP_W-1:0]             rem_r;
  logic                         busy_r, out_vld_r;
  logic [mpm_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [mpm_pkg::ENTRY_W-1:0]  hold_r;

  mpm_pkg::ucode_t              uw;
  mpm_pkg::tag_t                issue_tag, res_tag;
  logic [1:0]                   x_idx, y_idx;
  logic [mpm_pkg::ENTRY_W-1:0]  op_a, op_b, mm_res, acc_val;
  logic [mpm_pkg::ENTRY_W:0]    acc_sum;
  logic                         mm_busy, accept, done_fire, commit;

  assign uw        = mpm_pkg::ucode_rom(step_r);
  assign accept    = in_ch.valid && in_ch.ready;
  assign done_fire = busy_r && (uw.op == mpm_pkg::OP_DONE) && (!out_vld_r || out_ch.ready);
  assign commit    = busy_r && (uw.op == mpm_pkg::OP_COMMIT);

  // entry {r,c}: first product x[r][0]*s[0][c], second x[r][1]*s[1][c]
  assign x_idx = {uw.ent[1], uw.second};
  assign y_idx = {uw.second, uw.ent[0]};
  assign op_a  = (uw.bank == mpm_pkg::BANK_SQ) ? sq_r[x_idx] : acc_r[x_idx];
  assign op_b  = sq_r[y_idx];

  assign issue_tag = '{vld:    busy_r && (uw.op == mpm_pkg::OP_ISSUE),
                       bank:   uw.bank,
                       ent:    uw.ent,
                       second: uw.second};

  mpm_mulmod u_mulmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_tag (issue_tag),
    .op_a      (op_a),
    .op_b      (op_b),
    .res_tag   (res_tag),
    .res       (mm_res),
    .busy      (mm_busy)
  );

  always_comb begin
    step_nxt = step_r + mpm_pkg::STEP_W'(1);
    case (uw.op)
      mpm_pkg::OP_JZ: begin
        if (rem_r == '0) step_nxt = uw.target;
      end
      mpm_pkg::OP_JBC: begin
        if (!rem_r[0]) step_nxt = uw.target;
      end
      mpm_pkg::OP_WAIT: begin
        if (mm_busy) step_nxt = step_r;
      end
      mpm_pkg::OP_COMMIT: begin
        step_nxt = uw.target;
      end
      mpm_pkg::OP_DONE: begin
        step_nxt = step_r;
      end
      default: begin
      end
    endcase
  end

  // add the pair of products for one entry
  assign acc_sum = {1'b0, hold_r} + {1'b0, mm_res};
  assign acc_val = (acc_sum >= {1'b0, mpm_pkg::MOD_PRIME}) ?
                   mpm_pkg::ENTRY_W'(acc_sum - {1'b0, mpm_pkg::MOD_PRIME}) :
                   mpm_pkg::ENTRY_W'(acc_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= mpm_pkg::STEP_START;
      out_vld_r <= 1'b0;
      cfg_r     <= mpm_pkg::CFG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpm_pkg::REG_ENTRY_00: cfg_r[0] <= cfg_wdata;
          mpm_pkg::REG_ENTRY_01: cfg_r[1] <= cfg_wdata;
          mpm_pkg::REG_ENTRY_10: cfg_r[2] <= cfg_wdata;
          mpm_pkg::REG_ENTRY_11: cfg_r[3] <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        busy_r <= 1'b1;
        step_r <= mpm_pkg::STEP_START;
      end else if (busy_r) begin
        step_r <= step_nxt;
        if (done_fire) busy_r <= 1'b0;
      end
      if (done_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= mpm_pkg::IDENTITY;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= mpm_pkg::reduce_entry(cfg_r[i]);
      end
      rem_r <= in_ch.exponent[EXP_W-1:0];
    end else if (commit) begin
      if (rem_r[0]) acc_r <= nacc_r;
      sq_r  <= nsq_r;
      rem_r <= rem_r >> 1;
    end
    if (res_tag.vld) begin
      if (!res_tag.second) begin
        hold_r <= mm_res;
      end else if (res_tag.bank == mpm_pkg::BANK_SQ) begin
        nsq_r[res_tag.ent] <= acc_val;
      end else begin
        nacc_r[res_tag.ent] <= acc_val;
      end
    end
    if (done_fire) out_mat_r <= acc_r;
  end

  assign in_ch.ready     = !busy_r;
  assign out_ch.valid    = out_vld_r;
  assign out_ch.power_00 = out_mat_r[0];
  assign out_ch.power_01 = out_mat_r[1];
  assign out_ch.power_10 = out_mat_r[2];
  assign out_ch.power_11 = out_mat_r[3];

  `MPM_ASSERT_IMPL(a_commit_drained, commit, !mm_busy, "commit with products in flight")
  `MPM_ASSERT_IMPL(a_done_drained, busy_r && (uw.op == mpm_pkg::OP_DONE), !mm_busy, "finish with products in flight")
  `MPM_ASSERT(a_idle_quiet, busy_r || !mm_busy, "multiplier active while idle")
  `MPM_ASSERT_IMPL(a_result_reduced, out_vld_r, (out_mat_r[0] < mpm_pkg::MOD_PRIME) && (out_mat_r[1] < mpm_pkg::MOD_PRIME) && (out_mat_r[2] < mpm_pkg::MOD_PRIME) && (out_mat_r[3] < mpm_pkg::MOD_PRIME), "result entry not below the prime")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 modular matrix power. Exponents go in over
// the input channel, and each returned matrix is compared entry by entry with
// a square-and-multiply predictor. The base matrix is reprogrammed between
// phases, and both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRIME          = 1000000007;
  localparam int unsigned ENTRY_MAX      = (1 << mpm_pkg::ENTRY_W) - 1;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          TAIL_CYCLES    = 900;
  localparam int          HOLD_CYCLES    = 3000;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          PHASE_ITEMS    = 100;

  typedef logic [mpm_pkg::ENTRY_W-1:0]      entry_t;
  typedef logic [3:0][mpm_pkg::ENTRY_W-1:0] quad_t;  // [0]=00 [1]=01 [2]=10 [3]=11

  class power_scoreboard;
    entry_t base_reg [4];
    quad_t  pending [$];
    int     errors;

    function new();
      base_reg[0] = entry_t'(0);
      base_reg[1] = entry_t'(1);
      base_reg[2] = entry_t'(3);
      base_reg[3] = entry_t'(2);
      errors      = 0;
    endfunction

    function void write_reg(logic [mpm_pkg::CFG_IDX_W-1:0] idx, entry_t data);
      if (idx <= mpm_pkg::REG_ENTRY_11) base_reg[idx[1:0]] = data;
    endfunction

    function quad_t mat_mul(quad_t x, quad_t y);
      quad_t       r;
      logic [63:0] a;
      logic [63:0] b;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          a = (64'(x[2*i]) * 64'(y[j])) % 64'(PRIME);
          b = (64'(x[2*i+1]) * 64'(y[2+j])) % 64'(PRIME);
          r[2*i+j] = mpm_pkg::ENTRY_W'((a + b) % 64'(PRIME));
        end
      end
      return r;
    endfunction

    function quad_t raise(logic [mpm_pkg::EXP_IN_W-1:0] e);
      quad_t acc;
      quad_t sq;
      acc = '0;
      acc[0] = entry_t'(1);
      acc[3] = entry_t'(1);
      for (int i = 0; i < 4; i++)
        sq[i] = (base_reg[i] >= PRIME) ? entry_t'(base_reg[i] - PRIME) : base_reg[i];
      for (int k = 0; k < mpm_pkg::EXP_BITS_DFLT && k < mpm_pkg::EXP_IN_W; k++) begin
        if ((e >> k) == 0) break;
        if (e[k]) acc = mat_mul(acc, sq);
        sq = mat_mul(sq, sq);
      end
      return acc;
    endfunction

    function void note_exponent(logic [mpm_pkg::EXP_IN_W-1:0] e);
      pending.push_back(raise(e));
    endfunction

    function void check_power(quad_t got);
      quad_t want;
      if (pending.size() == 0) begin
        $error("matrix returned with no exponent pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          $error("power_%0d%0d: expected %0d, got %0d", i / 2, i % 2, want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mpm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mpm_pkg::ENTRY_W-1:0]   cfg_wdata;

  mpm_in_if  in_if ();
  mpm_out_if out_if ();

  matrix_power_2x2_mod_prime dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  power_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  bit hold_taken    = 1'b0;
  int quiet_cycles  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_exponent(in_if.exponent);
      if (out_if.valid && out_if.ready)
        sb.check_power({out_if.power_11, out_if.power_10, out_if.power_01, out_if.power_00});
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_exponent(input logic [mpm_pkg::EXP_IN_W-1:0] e);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.exponent <= e;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // drop valid and wait until every pending matrix is back
  task automatic drain();
    in_if.valid <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_base(input quad_t m, input bit junk);
    logic [mpm_pkg::CFG_IDX_W-1:0] bad_idx;
    entry_t                        bad_data;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= mpm_pkg::REG_ENTRY_00 + mpm_pkg::CFG_IDX_W'(i);
      cfg_wdata <= m[i];
      sb.write_reg(mpm_pkg::REG_ENTRY_00 + mpm_pkg::CFG_IDX_W'(i), m[i]);
      @(posedge clk);
    end
    // out-of-range index must leave the base alone
    if (junk) begin
      bad_idx  = mpm_pkg::CFG_IDX_W'($urandom_range(mpm_pkg::REG_ENTRY_11 + 1,
                                                    (1 << mpm_pkg::CFG_IDX_W) - 1));
      bad_data = entry_t'($urandom());
      cfg_index <= bad_idx;
      cfg_wdata <= bad_data;
      sb.write_reg(bad_idx, bad_data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [mpm_pkg::EXP_IN_W-1:0] first_exps [10];
    quad_t                        base;
    int unsigned                  sel;
    logic [mpm_pkg::EXP_IN_W-1:0] e;

    first_exps = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.exponent = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct <= 51;

    // reset base, bit-pattern exponents
    for (int i = 0; i < 10; i++) send_exponent(first_exps[i]);
    drain();

    // largest reduced entries
    load_base({4{entry_t'(PRIME - 1)}}, 1'b0);
    send_exponent(32'd0);
    send_exponent(32'd1);
    send_exponent(32'hFFFF_FFFF);
    drain();

    // entries above the prime, identity for exponent zero
    load_base({4{entry_t'(ENTRY_MAX)}}, 1'b1);
    send_exponent(32'd0);
    send_exponent(32'd1);
    send_exponent(32'd2);
    drain();

    // zero base
    load_base('0, 1'b1);
    send_exponent(32'd0);
    send_exponent(32'd1);
    send_exponent(32'h8000_0000);
    drain();

    // exactly the prime and just above it
    base[0] = entry_t'(PRIME);
    base[1] = entry_t'(PRIME + 1);
    base[2] = entry_t'(ENTRY_MAX - 1);
    base[3] = entry_t'(1);
    load_base(base, 1'b1);
    send_exponent(32'd5);
    send_exponent(32'hDEAD_BEEF);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct <= 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct <= 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      base[i] = entry_t'($urandom_range(0, PRIME - 1));
        else if (sel < 78) base[i] = '0;
        else if (sel < 86) base[i] = entry_t'(PRIME - 1);
        else if (sel < 94) base[i] = entry_t'($urandom_range(PRIME, ENTRY_MAX));
        else               base[i] = entry_t'($urandom_range(0, 9));
      end
      load_base(base, 1'($urandom_range(0, 1)));
      // hold the receiver off while exponents keep coming
      if (ph == 2) hold_request <= 1'b1;
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)      e = $urandom();
        else if (sel < 85) e = $urandom_range(0, 255);
        else if (sel < 93) e = 32'h1 << $urandom_range(0, mpm_pkg::EXP_IN_W - 1);
        else               e = 32'hFFFF_FFFF >> $urandom_range(0, mpm_pkg::EXP_IN_W - 1);
        send_exponent(e);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> matrix_power_2x2_mod_prime.f
+incdir+hdl
hdl/mpm_pkg.sv
hdl/mpm_in_if.sv
hdl/mpm_out_if.sv
hdl/mpm_mulmod.sv
hdl/matrix_power_2x2_mod_prime.sv
tb/tb_top.sv
